>>> hw/rtl/saoc_pkg.sv
// saoc_pkg: shared types, codes and sizes for the sorted array occurrence counter
// used by sorted_array_occurrence_counter, the scoreboard and the testbench; no dependencies
package saoc_pkg;

  // default store depth
  localparam int SAOC_DEPTH = 1024;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 10;
  localparam int OCC_W    = 11;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
  } saoc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  last_index;
    logic [OCC_W-1:0]    occurrences;
  } saoc_rsp_t;

endpackage

>>> hw/rtl/saoc_ram.sv
// saoc_ram: generic synchronous RAM, one write port and two registered read ports
// no dependencies
module saoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> hw/rtl/sorted_array_occurrence_counter.sv
// clear and append: result strobed in the cycle after the transfer, next request taken at once
// count query: one cycle per binary search step (probe and neighbour read together from the
// store RAM), a first-edge search and, on a hit, a last-edge search, busy meanwhile
// the receiver cannot stall: done marks each result for one cycle only
// reset clears the fill count and the sequencer; the store itself is not cleared
// and its contents are undefined until written
module sorted_array_occurrence_counter
  import saoc_pkg::*;
#(
  parameter int DEPTH = SAOC_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  saoc_req_t request,
  output logic      done,
  output saoc_rsp_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                      state;
  logic [CW-1:0]             fill;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [AW-1:0]             mid;
  logic [AW-1:0]             f_idx;
  logic                      toward_last;
  logic signed [VALUE_W-1:0] v;

  logic                      accept;
  logic [VALUE_W-1:0]        rd_data_a;
  logic [VALUE_W-1:0]        rd_data_b;
  logic                      probe_gt;
  logic                      probe_lt;
  logic                      nbr_eq;
  logic [CW-1:0]             mid_p1;
  logic                      at_edge;
  logic                      hit;
  logic                      restart;
  logic                      launch;
  logic                      tl_next;
  logic [CW-1:0]             lo_n;
  logic [CW-1:0]             hi_n;
  logic [CW-1:0]             lo_r;
  logic [CW-1:0]             hi_r;
  logic [CW:0]               mid_sum;
  logic [AW-1:0]             mid_n;
  logic [AW-1:0]             nbr_addr;
  logic                      wr_en;
  logic [CW-1:0]             occ_w;
  logic                      done_next;
  logic [STATUS_W-1:0]       idle_status;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (request.req_type == REQ_APPEND) && (fill < CW'(DEPTH));

  // probe compare and neighbour check
  assign probe_gt = $signed(rd_data_a) > v;
  assign probe_lt = $signed(rd_data_a) < v;
  assign nbr_eq   = $signed(rd_data_b) == v;
  assign mid_p1   = CW'(mid) + CW'(1);
  assign at_edge  = toward_last ? ((mid_p1 == fill) || !nbr_eq)
                                : ((mid == '0) || !nbr_eq);

  // one search step: narrow the range or stop on a boundary hit
  always_comb begin
    lo_n = lo;
    hi_n = hi;
    hit  = 1'b0;
    if (state == S_SEARCH) begin
      priority if (probe_gt) begin
        hi_n = CW'(mid);
      end else if (probe_lt) begin
        lo_n = mid_p1;
      end else if (at_edge) begin
        hit = 1'b1;
      end else if (toward_last) begin
        lo_n = mid_p1;
      end else begin
        hi_n = CW'(mid);
      end
    end
  end

  // next probe: fresh full range on a new query or the second search
  always_comb begin
    restart = ((state == S_IDLE) && accept && (request.req_type == REQ_COUNT)) ||
              ((state == S_SEARCH) && hit && !toward_last);
    if (restart) begin
      lo_r = '0;
      hi_r = fill;
    end else begin
      lo_r = lo_n;
      hi_r = hi_n;
    end
    launch  = restart ? (fill != '0) : ((state == S_SEARCH) && !hit && (lo_n < hi_n));
    tl_next = (state == S_SEARCH) && (toward_last || hit);
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
    mid_n   = AW'(mid_sum[CW:1]);
    nbr_addr = tl_next ? (mid_n + AW'(1)) : (mid_n - AW'(1));
  end

  assign occ_w = CW'(mid) - CW'(f_idx) + CW'(1);

  // result strobe for a request answered at once or a query that ends now
  assign done_next = busy ? !launch
                          : (accept && ((request.req_type == REQ_CLEAR) ||
                                        (request.req_type == REQ_APPEND) ||
                                        ((request.req_type == REQ_COUNT) && !launch)));

  // status of a request answered straight from idle
  always_comb begin
    unique case (request.req_type)
      REQ_CLEAR:  idle_status = ST_CLEARED;
      REQ_APPEND: idle_status = wr_en ? ST_APPENDED : ST_FULL;
      default:    idle_status = ST_ABSENT;
    endcase
  end

  saoc_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (AW'(fill)),
    .wr_data  (request.value),
    .rd_addr_a(mid_n),
    .rd_data_a(rd_data_a),
    .rd_addr_b(nbr_addr),
    .rd_data_b(rd_data_b)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      if (state == S_IDLE) begin
        if (accept) begin
          unique case (request.req_type)
            REQ_CLEAR: begin
              fill <= '0;
            end
            REQ_APPEND: begin
              if (wr_en) begin
                fill <= fill + CW'(1);
              end
            end
            REQ_COUNT: begin
              if (launch) begin
                state <= S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (!launch) begin
        state <= S_IDLE;
      end
    end
  end

  // search registers and result payload
  always_ff @(posedge clk) begin
    if (launch) begin
      lo          <= lo_r;
      hi          <= hi_r;
      mid         <= mid_n;
      toward_last <= tl_next;
    end
    if (accept) begin
      v <= request.value;
    end
    if ((state == S_SEARCH) && hit && !toward_last) begin
      f_idx <= mid;
    end
    if (state == S_IDLE) begin
      if (accept) begin
        result <= '{status: idle_status, first_index: '0, last_index: '0, occurrences: '0};
      end
    end else if (!launch) begin
      // end of query: found only on a last-edge hit at or after the first edge
      if (hit && (mid >= f_idx)) begin
        result <= '{status:      ST_FOUND,
                    first_index: INDEX_W'(f_idx),
                    last_index:  INDEX_W'(mid),
                    occurrences: OCC_W'(occ_w)};
      end else begin
        result <= '{status: ST_ABSENT, first_index: '0, last_index: '0, occurrences: '0};
      end
    end
  end

`ifndef SYNTHESIS
  // a clear is answered in the next cycle
  a_clear_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.req_type == REQ_CLEAR) |=>
      done && (result.status == ST_CLEARED))
    else $error("clear not answered in the next cycle");

  // anything but a hit carries zero indices and count
  a_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_FOUND) |->
      (result.first_index == '0) && (result.last_index == '0) && (result.occurrences == '0))
    else $error("non-found result with nonzero fields");

  // a dropped append only happens on a full store
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_FULL) |-> (fill == CW'(DEPTH)))
    else $error("append dropped while store not full");

  // the search only runs over a non-empty store
  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (fill != '0) && !done)
    else $error("search running over an empty store or overlapping a result");
`endif

endmodule

>>> verif/saoc_scoreboard_pkg.sv
`timescale 1ns / 100ps
// saoc_scoreboard_pkg: occurrence scoreboard for the sorted array occurrence counter bench,
// predicts every result from the accepted requests; depends on saoc_pkg
package saoc_scoreboard_pkg;
  import saoc_pkg::*;

  class occurrence_scoreboard;
    logic signed [VALUE_W-1:0] entries [SAOC_DEPTH];
    int                        fill_count;
    saoc_rsp_t                 expected_q[$];
    int unsigned               errors;

    function new();
      fill_count = 0;
      errors = 0;
    endfunction

    // binary search for one end of the run of entries equal to key
    function bit find_edge(logic signed [VALUE_W-1:0] key, bit toward_last,
                           output int where);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = fill_count - 1;
      where = 0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (entries[mid] > key) begin
          hi = mid - 1;
        end else if (entries[mid] < key) begin
          lo = mid + 1;
        end else if (toward_last) begin
          // stop once the right neighbour differs or lies past the filled part
          if (mid == fill_count - 1 || entries[mid + 1] != key) begin
            where = mid;
            return 1'b1;
          end
          lo = mid + 1;
        end else begin
          if (mid == 0 || entries[mid - 1] != key) begin
            where = mid;
            return 1'b1;
          end
          hi = mid - 1;
        end
      end
      return 1'b0;
    endfunction

    // update the predicted store for an accepted request and queue its result
    function void note_request(saoc_req_t req);
      saoc_rsp_t rsp;
      int        first_pos;
      int        last_pos;
      bit        hit_first;
      bit        hit_last;
      rsp = '0;
      case (req.req_type)
        REQ_CLEAR: begin
          fill_count = 0;
          rsp.status = ST_CLEARED;
        end
        REQ_APPEND: begin
          if (fill_count >= SAOC_DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            entries[fill_count] = req.value;
            fill_count++;
            rsp.status = ST_APPENDED;
          end
        end
        REQ_COUNT: begin
          hit_first = find_edge(req.value, 1'b0, first_pos);
          hit_last  = find_edge(req.value, 1'b1, last_pos);
          if (hit_first && hit_last && last_pos >= first_pos) begin
            rsp.status      = ST_FOUND;
            rsp.first_index = INDEX_W'(first_pos);
            rsp.last_index  = INDEX_W'(last_pos);
            rsp.occurrences = OCC_W'(last_pos - first_pos + 1);
          end else begin
            rsp.status = ST_ABSENT;
          end
        end
        // unused request code: no state change and no result
        default: return;
      endcase
      expected_q.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare a result transfer with the oldest prediction
    function void check_result(saoc_rsp_t got);
      saoc_rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("first_index", 16'(want.first_index), 16'(got.first_index));
      compare_field("last_index", 16'(want.last_index), 16'(got.last_index));
      compare_field("occurrences", 16'(want.occurrences), 16'(got.occurrences));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench: drives clear, append and count requests into sorted_array_occurrence_counter
// and checks each result transfer; depends on saoc_pkg and saoc_scoreboard_pkg
module testbench;
  import saoc_pkg::*;
  import saoc_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 200;
  localparam int IDLE_PERCENT   = 13;

  // request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam longint                    LONG_MIN  = -64'sd2147483648;
  localparam longint                    LONG_MAX  = 64'sd2147483647;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  saoc_req_t request = '0;
  logic      done;
  saoc_rsp_t result;

  occurrence_scoreboard scoreboard;
  bit                   gapless = 1'b0;
  int unsigned          items_sent = 0;
  int                   stall_cycles = 0;

  always #10 clk = ~clk;

  sorted_array_occurrence_counter i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // result check, request bookkeeping and watchdog, all on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (done) scoreboard.check_result(result);
      if (start && !busy) scoreboard.note_request(request);
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one request transfer: random gaps first, then hold start until the block takes it
  task automatic send(input logic [REQ_W-1:0] kind, input logic signed [VALUE_W-1:0] val);
    saoc_req_t req;
    req.req_type = kind;
    req.value    = val;
    while (!gapless && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // hold off until every predicted result has arrived
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (scoreboard.outstanding() != 0);
    @(posedge clk);
  endtask

  function automatic longint any_value();
    return longint'(int'($urandom));
  endfunction

  function automatic longint clamp(longint v);
    if (v > LONG_MAX) return LONG_MAX;
    if (v < LONG_MIN) return LONG_MIN;
    return v;
  endfunction

  // query key: mostly a held value, else a near miss or anything at all
  function automatic logic signed [VALUE_W-1:0] probe(input longint held[$]);
    int pick;
    pick = $urandom_range(9);
    if (held.size() == 0 || pick >= 8) return VALUE_W'(any_value());
    if (pick < 6) return VALUE_W'(held[$urandom_range(held.size() - 1)]);
    return VALUE_W'(clamp(held[$urandom_range(held.size() - 1)] +
                          ($urandom_range(1) ? 1 : -1)));
  endfunction

  // clear, then a non-decreasing run of appends with queries mixed in
  task automatic run_sorted(input int count, input int max_stride, input int query_pct);
    longint held[$];
    longint cur;
    int     k;
    send(REQ_CLEAR, VALUE_W'(any_value()));
    case ($urandom_range(3))
      0: cur = LONG_MIN + $urandom_range(50);
      1: cur = LONG_MAX - $urandom_range(5000);
      2: cur = longint'($urandom_range(40)) - 20;
      default: cur = any_value();
    endcase
    for (k = 0; k < count; k++) begin
      if (k > 0 && max_stride > 0) begin
        if ($urandom_range(19) == 0) cur = clamp(cur + $urandom_range(1 << 20));
        else cur = clamp(cur + $urandom_range(max_stride));
      end
      send(REQ_APPEND, VALUE_W'(cur));
      held.push_back(cur);
      if ($urandom_range(99) < query_pct) send(REQ_COUNT, probe(held));
    end
    repeat ($urandom_range(1, 8)) send(REQ_COUNT, probe(held));
  endtask

  // small values in random order, optionally on top of what the store holds
  task automatic run_unsorted(input bit clear_first);
    longint held[$];
    if (clear_first) send(REQ_CLEAR, VALUE_W'(any_value()));
    repeat ($urandom_range(1, 12)) begin
      held.push_back(longint'($urandom_range(6)) - 3);
      send(REQ_APPEND, VALUE_W'(held[$]));
    end
    repeat ($urandom_range(1, 6)) send(REQ_COUNT, VALUE_W'(longint'($urandom_range(8)) - 4));
  endtask

  initial begin
    int unsigned target;
    int          pick;
    scoreboard = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty store after reset, then a clear on an empty store
    send(REQ_COUNT, 32'sd0);
    send(REQ_CLEAR, 32'sd0);
    // runs at both extremes of the value range and in the middle
    send(REQ_APPEND, VALUE_MIN);
    send(REQ_APPEND, VALUE_MIN);
    send(REQ_APPEND, -32'sd1);
    send(REQ_APPEND, 32'sd0);
    send(REQ_APPEND, 32'sd0);
    send(REQ_APPEND, 32'sd0);
    send(REQ_APPEND, 32'sd1);
    send(REQ_APPEND, VALUE_MAX);
    send(REQ_APPEND, VALUE_MAX);
    send(REQ_COUNT, VALUE_MIN);
    send(REQ_COUNT, 32'sd0);
    send(REQ_COUNT, VALUE_MAX);
    send(REQ_COUNT, 32'sd5);
    // unused request code must leave the store alone
    send(REQ_UNUSED, -32'sd1);
    send(REQ_COUNT, -32'sd1);
    // unsorted contents
    send(REQ_CLEAR, 32'sd0);
    send(REQ_APPEND, 32'sd7);
    send(REQ_APPEND, 32'sd3);
    send(REQ_APPEND, 32'sd7);
    send(REQ_COUNT, 32'sd7);
    send(REQ_COUNT, 32'sd3);
    drain();

    // full store of one value, appends dropped at the end, no gaps from the sender
    gapless = 1'b1;
    run_sorted(SAOC_DEPTH + 2, 0, 1);
    gapless = 1'b0;
    drain();

    // random sequences, mostly well-formed sorted fills
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_sorted(($urandom_range(19) == 0) ? $urandom_range(25, 60) : $urandom_range(24),
                   $urandom_range(3), 15);
      end else if (pick < 85) begin
        run_unsorted(1'b1);
      end else if (pick < 95) begin
        run_unsorted(1'b0);
      end else begin
        send(REQ_UNUSED, VALUE_W'(any_value()));
        send(REQ_COUNT, VALUE_W'(any_value()));
      end
      if ($urandom_range(9) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
